// File: src/pswt_pkg.sv
`timescale 1ns / 1ps
package pswt_pkg;

   localparam int BURST_W = 16;
   localparam int PRIO_W  = 8;
   localparam int NUM_W   = 5;
   localparam int TIME_W  = 20;
   localparam logic [TIME_W-1:0] TIME_MAX = 20'hFFFFF;

   typedef struct packed {
      logic [BURST_W-1:0] burst;
      logic [PRIO_W-1:0]  priority_req;
      logic               last;
   } req_type;

   typedef struct packed {
      logic [NUM_W-1:0]   job_number;
      logic [BURST_W-1:0] job_burst;
      logic [TIME_W-1:0]  wait_time;
      logic [TIME_W-1:0]  turnaround;
      logic [TIME_W-1:0]  avg_wait;
      logic [TIME_W-1:0]  avg_turnaround;
      logic               overflow;
      logic               end_of_run;
   } rsp_type;

   // One stored job as it sits in the job memory.
   typedef struct packed {
      logic [NUM_W-1:0]   number;
      logic [PRIO_W-1:0]  prio;
      logic [BURST_W-1:0] burst;
   } job_type;

   localparam int JOB_W = $bits(job_type);

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_SCAN,
      ST_SWAP_A,
      ST_SWAP_B,
      ST_DIV_W,
      ST_DIV_T,
      ST_EMIT_RD,
      ST_EMIT_DATA
   } state_type;

endpackage

// File: src/pswt_req_if.sv
`timescale 1ns / 1ps
interface pswt_req_if;
   import pswt_pkg::*;

   logic    valid;
   logic    ready;
   req_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// File: src/pswt_rsp_if.sv
`timescale 1ns / 1ps
interface pswt_rsp_if;
   import pswt_pkg::*;

   logic    valid;
   logic    ready;
   rsp_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// File: src/priority_schedule_wait_times.sv
`timescale 1ns / 1ps
// Non-preemptive priority scheduler. Jobs arrive on req_chan, one word per
// job (burst, priority, last flag), and are taken one per cycle into a job
// memory of MAX_JOBS entries. Jobs beyond capacity are dropped and flagged.
// The word with last set closes the set: the block stops taking words,
// selection-sorts the memory by priority, reading the slots from the
// current one to the end of the set on each pass, then runs two
// serial divisions for the averages (one bit per cycle). It then sends
// one word per job on rsp_chan, each paced by a read through the
// single read port of the job memory.
// A stalled rsp_chan holds the result word in the output register and
// pauses the readout; after the final word the block takes new jobs again,
// even while that final word still waits. Reset empties the set and
// clears the output valid; the memory contents need no clearing.
module priority_schedule_wait_times #(
   parameter int MAX_JOBS = 16
) (
   input  logic       clock,
   input  logic       reset,
   pswt_req_if.sink   req_chan,
   pswt_rsp_if.source rsp_chan
);
   import pswt_pkg::*;

   localparam int IDX_W   = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
   localparam int CNT_W   = $clog2(MAX_JOBS + 1);
   localparam int RUN_W   = (BURST_W + CNT_W > TIME_W + 1) ? BURST_W + CNT_W : TIME_W + 1;
   localparam int SUM_W   = RUN_W + 1;
   localparam int TOT_W   = (BURST_W + 2 * CNT_W > TIME_W + 1) ?
                            BURST_W + 2 * CNT_W : TIME_W + 1;

   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               dropped_ff, dropped_in;
   logic [CNT_W-1:0]   slot_ff, slot_in;
   logic [CNT_W-1:0]   scan_ff, scan_in;
   logic               rd_vld_ff, rd_vld_in;
   logic [CNT_W-1:0]   rd_idx_ff, rd_idx_in;
   logic [CNT_W-1:0]   pos_ff, pos_in;
   logic [CNT_W-1:0]   emit_ff, emit_in;
   job_type            cur_ff, cur_in;
   job_type            min_ff, min_in;
   logic [RUN_W-1:0]   run_ff, run_in;
   logic [TOT_W-1:0]   tot_wt_ff, tot_wt_in;
   logic [TOT_W-1:0]   tot_tat_ff, tot_tat_in;
   logic [TIME_W-1:0]  avg_w_ff, avg_w_in;
   logic [TIME_W-1:0]  avg_t_ff, avg_t_in;
   logic               rsp_vld_ff, rsp_vld_in;
   rsp_type            rsp_data_ff, rsp_data_in;

   logic               accept;
   logic               ram_we;
   logic [IDX_W-1:0]   ram_waddr;
   job_type            ram_wdata;
   logic [IDX_W-1:0]   ram_raddr;
   logic [JOB_W-1:0]   ram_rdata;
   job_type            rd_job;
   logic               issue;
   logic               div_start;
   logic [TOT_W-1:0]   div_dividend;
   logic               div_done;
   logic [TOT_W-1:0]   div_quotient;
   logic [SUM_W-1:0]   tat_sum;

   function automatic logic [TIME_W-1:0] sat_sum(input logic [SUM_W-1:0] v);
      return (v > SUM_W'(TIME_MAX)) ? TIME_MAX : v[TIME_W-1:0];
   endfunction

   function automatic logic [TIME_W-1:0] sat_tot(input logic [TOT_W-1:0] v);
      return (v > TOT_W'(TIME_MAX)) ? TIME_MAX : v[TIME_W-1:0];
   endfunction

   pswt_ram #(
      .WIDTH (JOB_W),
      .DEPTH (MAX_JOBS)
   ) u_job_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   pswt_div #(
      .DIVIDEND_W (TOT_W),
      .DIVISOR_W  (CNT_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (count_ff),
      .done     (div_done),
      .quotient (div_quotient)
   );

   assign rd_job          = job_type'(ram_rdata);
   assign req_chan.ready  = (state_ff == ST_LOAD);
   assign accept          = req_chan.valid && req_chan.ready;
   assign rsp_chan.valid  = rsp_vld_ff;
   assign rsp_chan.data   = rsp_data_ff;
   assign tat_sum         = {1'b0, run_ff} + SUM_W'(rd_job.burst);

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      dropped_in   = dropped_ff;
      slot_in      = slot_ff;
      scan_in      = scan_ff;
      rd_vld_in    = 1'b0;
      rd_idx_in    = rd_idx_ff;
      pos_in       = pos_ff;
      emit_in      = emit_ff;
      cur_in       = cur_ff;
      min_in       = min_ff;
      run_in       = run_ff;
      tot_wt_in    = tot_wt_ff;
      tot_tat_in   = tot_tat_ff;
      avg_w_in     = avg_w_ff;
      avg_t_in     = avg_t_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_vld_in   = rsp_vld_ff && !rsp_chan.ready;
      ram_we       = 1'b0;
      ram_waddr    = '0;
      ram_wdata    = '0;
      ram_raddr    = '0;
      issue        = 1'b0;
      div_start    = 1'b0;
      div_dividend = tot_tat_ff;

      unique case (state_ff)
         ST_LOAD: begin
            if (accept) begin
               if (count_ff < CNT_W'(MAX_JOBS)) begin
                  ram_we          = 1'b1;
                  ram_waddr       = count_ff[IDX_W-1:0];
                  ram_wdata.burst = req_chan.data.burst;
                  ram_wdata.prio  = req_chan.data.priority_req;
                  ram_wdata.number = NUM_W'({1'b0, count_ff} + 1'b1);
                  count_in        = count_ff + 1'b1;
               end else begin
                  dropped_in = 1'b1;
               end
               if (req_chan.data.last) begin
                  state_in   = ST_SCAN;
                  slot_in    = '0;
                  scan_in    = '0;
                  run_in     = '0;
                  tot_wt_in  = '0;
                  tot_tat_in = '0;
               end
            end
         end

         ST_SCAN: begin
            // Reads stream from the slot to the end of the set; each word
            // comes back in the cycle after its read and is checked against the minimum.
            issue     = (scan_ff < count_ff);
            ram_raddr = scan_ff[IDX_W-1:0];
            rd_vld_in = issue;
            rd_idx_in = scan_ff;
            if (issue) begin
               scan_in = scan_ff + 1'b1;
            end
            if (rd_vld_ff) begin
               if (rd_idx_ff == slot_ff) begin
                  cur_in = rd_job;
                  min_in = rd_job;
                  pos_in = rd_idx_ff;
               end else if (rd_job.prio < min_ff.prio) begin
                  min_in = rd_job;
                  pos_in = rd_idx_ff;
               end
               if (CNT_W'(rd_idx_ff + 1'b1) == count_ff) begin
                  state_in = ST_SWAP_A;
               end
            end
         end

         ST_SWAP_A: begin
            ram_we    = 1'b1;
            ram_waddr = pos_ff[IDX_W-1:0];
            ram_wdata = cur_ff;
            state_in  = ST_SWAP_B;
         end

         ST_SWAP_B: begin
            // The minimum lands in its final slot; fold it into the totals.
            ram_we     = 1'b1;
            ram_waddr  = slot_ff[IDX_W-1:0];
            ram_wdata  = min_ff;
            run_in     = run_ff + RUN_W'(min_ff.burst);
            tot_wt_in  = tot_wt_ff + TOT_W'(run_ff);
            tot_tat_in = tot_tat_ff + TOT_W'(run_in);
            slot_in    = slot_ff + 1'b1;
            if (CNT_W'(slot_ff + 1'b1) == count_ff) begin
               state_in     = ST_DIV_W;
               div_start    = 1'b1;
               div_dividend = tot_wt_in;
            end else begin
               state_in = ST_SCAN;
               scan_in  = slot_ff + 1'b1;
            end
         end

         ST_DIV_W: begin
            if (div_done) begin
               avg_w_in     = sat_tot(div_quotient);
               div_start    = 1'b1;
               div_dividend = tot_tat_ff;
               state_in     = ST_DIV_T;
            end
         end

         ST_DIV_T: begin
            if (div_done) begin
               avg_t_in = sat_tot(div_quotient);
               run_in   = '0;
               emit_in  = '0;
               state_in = ST_EMIT_RD;
            end
         end

         ST_EMIT_RD: begin
            // Only fetch when the output register is free by the next edge.
            if (!rsp_vld_ff || rsp_chan.ready) begin
               ram_raddr = emit_ff[IDX_W-1:0];
               state_in  = ST_EMIT_DATA;
            end
         end

         ST_EMIT_DATA: begin
            rsp_vld_in                 = 1'b1;
            rsp_data_in.job_number     = rd_job.number;
            rsp_data_in.job_burst      = rd_job.burst;
            rsp_data_in.wait_time      = sat_sum({1'b0, run_ff});
            rsp_data_in.turnaround     = sat_sum(tat_sum);
            rsp_data_in.avg_wait       = avg_w_ff;
            rsp_data_in.avg_turnaround = avg_t_ff;
            rsp_data_in.overflow       = dropped_ff;
            rsp_data_in.end_of_run     = (CNT_W'(emit_ff + 1'b1) == count_ff);
            run_in                     = tat_sum[RUN_W-1:0];
            emit_in                    = emit_ff + 1'b1;
            if (CNT_W'(emit_ff + 1'b1) == count_ff) begin
               state_in   = ST_LOAD;
               count_in   = '0;
               dropped_in = 1'b0;
            end else begin
               state_in = ST_EMIT_RD;
            end
         end

         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_LOAD;
         count_ff   <= '0;
         dropped_ff <= 1'b0;
         slot_ff    <= '0;
         scan_ff    <= '0;
         rd_vld_ff  <= 1'b0;
         emit_ff    <= '0;
         rsp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         dropped_ff <= dropped_in;
         slot_ff    <= slot_in;
         scan_ff    <= scan_in;
         rd_vld_ff  <= rd_vld_in;
         emit_ff    <= emit_in;
         rsp_vld_ff <= rsp_vld_in;
      end
      rd_idx_ff   <= rd_idx_in;
      pos_ff      <= pos_in;
      cur_ff      <= cur_in;
      min_ff      <= min_in;
      run_ff      <= run_in;
      tot_wt_ff   <= tot_wt_in;
      tot_tat_ff  <= tot_tat_in;
      avg_w_ff    <= avg_w_in;
      avg_t_ff    <= avg_t_in;
      rsp_data_ff <= rsp_data_in;
   end
endmodule

// File: src/pswt_ram.sv
`timescale 1ns / 1ps
module pswt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                   clock,
   input  logic                                   we,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                       wdata,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                       rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule

// File: src/pswt_div.sv
`timescale 1ns / 1ps
module pswt_div #(
   parameter int DIVIDEND_W = 26,
   parameter int DIVISOR_W  = 5
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DIVIDEND_W-1:0] dividend,
   input  logic [DIVISOR_W-1:0]  divisor,
   output logic                  done,
   output logic [DIVIDEND_W-1:0] quotient
);
   localparam int STEP_W = $clog2(DIVIDEND_W + 1);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [STEP_W-1:0]     step_ff, step_in;
   logic [DIVISOR_W:0]    rem_ff, rem_in;
   logic [DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [DIVISOR_W:0]    shifted;
   logic                  fits;

   // Restoring division, one quotient bit per cycle, MSB first.
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      shifted = {rem_ff[DIVISOR_W-1:0], quo_ff[DIVIDEND_W-1]};
      fits    = (shifted >= {1'b0, divisor});
      if (start) begin
         busy_in = 1'b1;
         step_in = STEP_W'(DIVIDEND_W);
         rem_in  = '0;
         quo_in  = dividend;
      end else if (busy_ff) begin
         rem_in  = fits ? (shifted - {1'b0, divisor}) : shifted;
         quo_in  = {quo_ff[DIVIDEND_W-2:0], fits};
         step_in = step_ff - 1'b1;
         if (step_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;
endmodule
